/* hw/rtl/onewire_bus_master_defines.svh */
// ----------------------------------------------------------------------------
// onewire_bus_master_defines
// Assertion macros shared by the one-wire bus master RTL.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_BUS_MASTER_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on aclk, masked while aresetn is low
`define OWB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// property checked on aclk, also during reset
`define OWB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define OWB_ASSERT(lbl, prop, msg)
`define OWB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/owb_pkg.sv */
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types, register map and helpers of the one-wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

    localparam int TIMER_BITS = 10;
    localparam int CFG_BITS   = 10;

    typedef logic [TIMER_BITS-1:0] tmr_t;
    typedef logic [CFG_BITS-1:0]   cfg_val_t;
    typedef logic [2:0]            cfg_idx_t;

    // commands
    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // register map
    localparam cfg_idx_t REG_RESET_LOW    = 3'd0;
    localparam cfg_idx_t REG_PRES_SAMPLE  = 3'd1;
    localparam cfg_idx_t REG_PRES_END     = 3'd2;
    localparam cfg_idx_t REG_LONG_SLOT    = 3'd3;
    localparam cfg_idx_t REG_SHORT_PULSE  = 3'd4;
    localparam cfg_idx_t REG_READ_SAMPLE  = 3'd5;
    localparam cfg_idx_t REG_READ_TAIL    = 3'd6;
    localparam cfg_idx_t REG_POLL_LIMIT   = 3'd7;

    // reset values
    localparam cfg_val_t RST_RESET_LOW   = 10'd500;
    localparam cfg_val_t RST_PRES_SAMPLE = 10'd80;
    localparam cfg_val_t RST_PRES_END    = 10'd60;
    localparam cfg_val_t RST_LONG_SLOT   = 10'd60;
    localparam cfg_val_t RST_SHORT_PULSE = 10'd2;
    localparam cfg_val_t RST_READ_SAMPLE = 10'd10;
    localparam cfg_val_t RST_READ_TAIL   = 10'd58;
    localparam cfg_val_t RST_POLL_LIMIT  = 10'd255;

    typedef struct packed {
        cfg_val_t reset_low_time;
        cfg_val_t presence_sample_time;
        cfg_val_t presence_end_time;
        cfg_val_t long_slot_time;
        cfg_val_t short_pulse_time;
        cfg_val_t read_sample_time;
        cfg_val_t read_tail_time;
        cfg_val_t presence_poll_limit;
    } owb_cfg_t;

    typedef struct packed {
        logic       status;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } owb_res_t;

    // phase length: zero counts as one tick, saturates at the timer range
    function automatic tmr_t dur(input cfg_val_t v);
        cfg_val_t w;
        w = (v == '0) ? cfg_val_t'(1) : v;
        if (32'(w) > (2 ** TIMER_BITS) - 1) begin
            return '1;
        end
        return tmr_t'(w);
    endfunction

endpackage

/* hw/rtl/owb_seq.sv */
// ----------------------------------------------------------------------------
// owb_seq
// Slot sequencer: advances the bus state by one tick per accepted transaction.
// ----------------------------------------------------------------------------
`include "onewire_bus_master_defines.svh"

module owb_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              cmd_valid,
    input  logic [1:0]        op,
    input  logic [7:0]        tx_byte,
    input  logic              bus_level,
    input  owb_pkg::owb_cfg_t cfg,
    output owb_pkg::owb_res_t res
);
    import owb_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_POLL, PH_RST_REC,
        PH_WR_LOW, PH_WR_REL, PH_RD_LOW, PH_RD_REL, PH_RD_TAIL, PH_RD_WAIT
    } phase_t;

    phase_t     phase_reg, phase_next;
    tmr_t       tmr_reg, tmr_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    cfg_val_t   poll_reg, poll_next;
    logic [7:0] rx_reg, rx_next;
    logic       err_reg, err_next;
    logic       done;
    logic       drive;
    logic       rd_end;

    always_comb begin
        phase_next = phase_reg;
        tmr_next   = tmr_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        rx_next    = rx_reg;
        err_next   = err_reg;
        done       = 1'b0;
        rd_end     = 1'b0;

        // command start, only from idle
        if (phase_reg == PH_IDLE && cmd_valid && op != OP_NONE) begin
            err_next = 1'b0;
            bit_next = 3'd0;
            case (op)
                OP_RESET: begin
                    phase_next = PH_RST_LOW;
                    tmr_next   = dur(cfg.reset_low_time);
                end
                OP_WRITE: begin
                    shift_next = tx_byte;
                    phase_next = PH_WR_LOW;
                    tmr_next   = dur(tx_byte[0] ? cfg.short_pulse_time : cfg.long_slot_time);
                end
                OP_READ: begin
                    shift_next = 8'd0;
                    phase_next = PH_RD_LOW;
                    tmr_next   = dur(cfg.short_pulse_time);
                end
                default: ;
            endcase
        end

        drive = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW)
             || (phase_next == PH_RD_LOW);

        if (phase_next == PH_RD_WAIT) begin
            rd_end = bus_level;
        end else if (phase_next != PH_IDLE) begin
            if (tmr_next > tmr_t'(1)) begin
                tmr_next = tmr_next - tmr_t'(1);
            end else begin
                unique case (phase_next)
                    PH_RST_LOW: begin
                        phase_next = PH_RST_WAIT;
                        tmr_next   = dur(cfg.presence_sample_time);
                    end
                    PH_RST_WAIT: begin
                        if (bus_level) begin
                            err_next   = 1'b1;
                            phase_next = PH_IDLE;
                            tmr_next   = '0;
                            done       = 1'b1;
                        end else begin
                            poll_next  = cfg.presence_poll_limit;
                            phase_next = PH_RST_POLL;
                            tmr_next   = dur(cfg.short_pulse_time);
                        end
                    end
                    PH_RST_POLL: begin
                        if (poll_next == '0) begin
                            err_next   = 1'b1;
                            phase_next = PH_IDLE;
                            tmr_next   = '0;
                            done       = 1'b1;
                        end else begin
                            poll_next = poll_next - cfg_val_t'(1);
                            if (bus_level) begin
                                phase_next = PH_RST_REC;
                                tmr_next   = dur(cfg.presence_end_time);
                            end else begin
                                tmr_next   = dur(cfg.short_pulse_time);
                            end
                        end
                    end
                    PH_WR_LOW: begin
                        phase_next = PH_WR_REL;
                        tmr_next   = dur(shift_next[0] ? cfg.long_slot_time
                                                       : cfg.short_pulse_time);
                    end
                    PH_WR_REL: begin
                        if (bit_next == 3'd7) begin
                            phase_next = PH_IDLE;
                            tmr_next   = '0;
                            done       = 1'b1;
                        end else begin
                            bit_next   = bit_next + 3'd1;
                            shift_next = {1'b0, shift_next[7:1]};
                            phase_next = PH_WR_LOW;
                            tmr_next   = dur(shift_next[0] ? cfg.short_pulse_time
                                                           : cfg.long_slot_time);
                        end
                    end
                    PH_RD_LOW: begin
                        phase_next = PH_RD_REL;
                        tmr_next   = dur(cfg.read_sample_time);
                    end
                    PH_RD_REL: begin
                        shift_next = {bus_level, shift_next[7:1]};
                        if (bus_level) begin
                            phase_next = PH_RD_TAIL;
                            tmr_next   = dur(cfg.read_tail_time);
                        end else begin
                            phase_next = PH_RD_WAIT;
                            tmr_next   = '0;
                        end
                    end
                    PH_RD_TAIL: rd_end = 1'b1;
                    default: begin
                        // recovery end and any stray phase
                        phase_next = PH_IDLE;
                        tmr_next   = '0;
                        done       = 1'b1;
                    end
                endcase
            end
        end

        // end of one read bit
        if (rd_end) begin
            if (bit_next == 3'd7) begin
                rx_next    = shift_next;
                phase_next = PH_IDLE;
                tmr_next   = '0;
                done       = 1'b1;
            end else begin
                bit_next   = bit_next + 3'd1;
                phase_next = PH_RD_LOW;
                tmr_next   = dur(cfg.short_pulse_time);
            end
        end

        res.drive_low = drive;
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.rx_byte   = rx_next;
        res.status    = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tmr_reg   <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            poll_reg  <= '0;
            rx_reg    <= '0;
            err_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            tmr_reg   <= tmr_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            rx_reg    <= rx_next;
            err_reg   <= err_next;
        end
    end

    `OWB_ASSERT_ALWAYS(a_idle_timer_clear, phase_reg == PH_IDLE |-> tmr_reg == '0, "timer left running in idle")
    `OWB_ASSERT(a_state_holds, !step && aresetn |=> $stable(phase_reg) && $stable(tmr_reg), "state moved without a tick")
    `OWB_ASSERT(a_done_not_busy, step && res.done_res |-> !res.busy_res, "done while still busy")
    `OWB_ASSERT(a_drive_busy, step && res.drive_low |-> res.busy_res, "line driven with no command")

endmodule

/* hw/rtl/onewire_bus_master.sv */
// ----------------------------------------------------------------------------
// onewire_bus_master
// One-wire bus master stepped once per microsecond tick transaction.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one transaction per microsecond tick; s_tuser carries the
//     command strobe and opcode, s_tdata the byte to write and the sampled
//     line level. a command starts only when the sequencer is idle.
//   m_ channel: exactly one result transaction per input transaction with
//     drive, busy, done, last received byte and status.
//   cfg_ port: timing registers, written while no command is running.
//   output: a tick's result is registered in the output stage, or first in
//     the skid entry; one tick is accepted every cycle while it is free,
//     the sequencer step being one pass from its state registers to the result.
//   reset: aresetn low clears the sequencer to idle, status and received
//     byte to zero, loads the default timings and empties the output stage.
//   stall: with m_tready low a second result lands in the skid register,
//     then s_tready drops until the skid entry moves into the output stage.
// ----------------------------------------------------------------------------
`include "onewire_bus_master_defines.svh"

module onewire_bus_master (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_we,
    input  owb_pkg::cfg_idx_t     cfg_index,
    input  owb_pkg::cfg_val_t     cfg_data,
    // tick input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // tx_byte[7:0], bus_level[8], zeros
    input  logic [2:0]            s_tuser,   // cmd_valid[0], op[2:1]
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata    // drive_low, busy_res, done_res,
                                             // rx_byte[10:3], status[11], zeros
);
    import owb_pkg::*;

    owb_cfg_t cfg_reg;
    owb_res_t res;
    owb_res_t out_data_reg;
    owb_res_t skid_data_reg;
    logic     out_valid_reg;
    logic     skid_valid_reg;
    logic     in_acc;
    logic     out_take;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_time       <= RST_RESET_LOW;
            cfg_reg.presence_sample_time <= RST_PRES_SAMPLE;
            cfg_reg.presence_end_time    <= RST_PRES_END;
            cfg_reg.long_slot_time       <= RST_LONG_SLOT;
            cfg_reg.short_pulse_time     <= RST_SHORT_PULSE;
            cfg_reg.read_sample_time     <= RST_READ_SAMPLE;
            cfg_reg.read_tail_time       <= RST_READ_TAIL;
            cfg_reg.presence_poll_limit  <= RST_POLL_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RESET_LOW:   cfg_reg.reset_low_time       <= cfg_data;
                REG_PRES_SAMPLE: cfg_reg.presence_sample_time <= cfg_data;
                REG_PRES_END:    cfg_reg.presence_end_time    <= cfg_data;
                REG_LONG_SLOT:   cfg_reg.long_slot_time       <= cfg_data;
                REG_SHORT_PULSE: cfg_reg.short_pulse_time     <= cfg_data;
                REG_READ_SAMPLE: cfg_reg.read_sample_time     <= cfg_data;
                REG_READ_TAIL:   cfg_reg.read_tail_time       <= cfg_data;
                REG_POLL_LIMIT:  cfg_reg.presence_poll_limit  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input accepted whenever the skid slot is free
    assign s_tready = !skid_valid_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    // sequencer: one tick per accepted transaction
    owb_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_acc),
        .cmd_valid (s_tuser[0]),
        .op        (s_tuser[2:1]),
        .tx_byte   (s_tdata[7:0]),
        .bus_level (s_tdata[8]),
        .cfg       (cfg_reg),
        .res       (res)
    );

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || out_take) begin
                if (skid_valid_reg) begin
                    // drain skid first, no input taken while it is full
                    out_data_reg   <= skid_data_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_acc;
                    if (in_acc) begin
                        out_data_reg <= res;
                    end
                end
            end else if (in_acc) begin
                // receiver stalled, park the result
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg.status, out_data_reg.rx_byte,
                       out_data_reg.done_res, out_data_reg.busy_res,
                       out_data_reg.drive_low};

    `OWB_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid entry with empty output stage")
    `OWB_ASSERT(a_skid_order, skid_valid_reg && !m_tready |=> skid_valid_reg && $stable(skid_data_reg), "skid entry lost while stalled")

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the one-wire bus master: every microsecond tick
// is fed through a cycle-true sequencer model and each result transaction is
// compared field by field. Default timings and a directed table come first,
// then extreme and random timing sets, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;
    import owb_pkg::*;

    localparam int       WATCHDOG_LIMIT = 2000;
    localparam int       ITEMS          = 1850;
    localparam cfg_val_t CFG_MAX        = '1;

    // sequencer phases of the model
    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_POLL, SEQ_RST_REC,
        SEQ_WR_LOW, SEQ_WR_REL, SEQ_RD_LOW, SEQ_RD_REL, SEQ_RD_TAIL, SEQ_RD_WAIT
    } seq_phase_e;

    // line level used while a command runs out
    typedef enum logic [2:0] {
        FILL_NONE, FILL_LOW, FILL_HIGH, FILL_TOGGLE, FILL_RANDOM
    } fill_e;

    typedef struct packed {
        logic       cv;
        logic [1:0] op;
        logic [7:0] tx;
        logic       lvl;
        fill_e      fill;   // run the command out with this line level
        logic       typed;  // want holds the expected result
        owb_res_t   want;
    } dir_row_t;

    localparam owb_cfg_t DEFAULT_TIMINGS = '{
        RST_RESET_LOW, RST_PRES_SAMPLE, RST_PRES_END, RST_LONG_SLOT,
        RST_SHORT_PULSE, RST_READ_SAMPLE, RST_READ_TAIL, RST_POLL_LIMIT
    };
    // every phase one tick, one presence poll allowed, two-tick long slot
    localparam owb_cfg_t FAST_TIMINGS = '{
        10'd1, 10'd1, 10'd1, 10'd2, 10'd1, 10'd1, 10'd1, 10'd1
    };

    localparam owb_res_t RES_IDLE = '0;
    localparam owb_res_t RES_LOW_BUSY = '{status: 1'b0, rx_byte: 8'h00,
        done_res: 1'b0, busy_res: 1'b1, drive_low: 1'b1};
    localparam owb_res_t RES_NO_PRESENCE = '{status: 1'b1, rx_byte: 8'h00,
        done_res: 1'b1, busy_res: 1'b0, drive_low: 1'b0};

    // directed ticks, run under FAST_TIMINGS
    localparam int DIR_ROWS = 17;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // idle between commands, then an invalid opcode that must be ignored
        '{1'b0, OP_RESET, 8'h00, 1'b1, FILL_NONE,   1'b1, RES_IDLE},
        '{1'b1, OP_NONE,  8'hff, 1'b1, FILL_NONE,   1'b1, RES_IDLE},
        // reset with the line high at the sample: no presence
        '{1'b1, OP_RESET, 8'h00, 1'b1, FILL_NONE,   1'b1, RES_LOW_BUSY},
        '{1'b0, OP_RESET, 8'h00, 1'b1, FILL_NONE,   1'b1, RES_NO_PRESENCE},
        // line held low through every poll: presence timeout
        '{1'b1, OP_RESET, 8'h00, 1'b0, FILL_LOW,    1'b1, RES_LOW_BUSY},
        // presence pulse ending on the first poll, then recovery
        '{1'b1, OP_RESET, 8'h00, 1'b0, FILL_NONE,   1'b1, RES_LOW_BUSY},
        '{1'b0, OP_RESET, 8'h00, 1'b0, FILL_NONE,   1'b0, RES_IDLE},
        '{1'b0, OP_RESET, 8'h00, 1'b1, FILL_HIGH,   1'b0, RES_IDLE},
        // byte extremes on write
        '{1'b1, OP_WRITE, 8'h00, 1'b1, FILL_HIGH,   1'b0, RES_IDLE},
        '{1'b1, OP_WRITE, 8'hff, 1'b0, FILL_LOW,    1'b0, RES_IDLE},
        // commands arriving while busy are dropped
        '{1'b1, OP_WRITE, 8'h5a, 1'b1, FILL_NONE,   1'b0, RES_IDLE},
        '{1'b1, OP_READ,  8'h00, 1'b1, FILL_NONE,   1'b0, RES_IDLE},
        '{1'b1, OP_NONE,  8'h3c, 1'b0, FILL_TOGGLE, 1'b0, RES_IDLE},
        // read of all ones, then mixed bits with waits for the line to rise
        '{1'b1, OP_READ,  8'h00, 1'b1, FILL_HIGH,   1'b0, RES_IDLE},
        '{1'b1, OP_READ,  8'h00, 1'b0, FILL_TOGGLE, 1'b0, RES_IDLE},
        '{1'b1, OP_RESET, 8'h00, 1'b1, FILL_TOGGLE, 1'b0, RES_IDLE},
        '{1'b0, OP_NONE,  8'h00, 1'b0, FILL_NONE,   1'b0, RES_IDLE}
    };

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    cfg_idx_t          cfg_index = REG_RESET_LOW;
    cfg_val_t          cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;  // tx_byte[7:0], bus_level[8], zeros
    logic [2:0]        s_tuser   = '0;  // cmd_valid[0], op[2:1]
    logic              m_tvalid;
    logic              m_tready  = 1'b1;
    logic [15:0]       m_tdata;         // drive_low[0], busy_res[1], done_res[2],
                                        // rx_byte[10:3], status[11], zeros

    // sequencer model state
    owb_cfg_t   timings  = DEFAULT_TIMINGS;
    seq_phase_e ph       = SEQ_IDLE;
    tmr_t       tmr      = '0;
    logic [2:0] bitn     = '0;
    logic [7:0] shreg    = '0;
    logic [9:0] polls    = '0;
    logic [7:0] rx_last  = '0;
    logic       err_flag = 1'b0;
    logic       fin      = 1'b0;

    owb_res_t   expected_ticks[$];
    int         mismatches   = 0;
    int         result_idx   = 0;
    int         sent_ticks   = 0;
    int         idle_cycles  = 0;
    int         stall_left   = 0;
    int         lvl_bias     = 50;
    bit         no_idling    = 1'b0;
    logic       toggle_lvl   = 1'b0;

    onewire_bus_master DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------
    // a zero register value still lasts one tick
    function automatic tmr_t span(input cfg_val_t v);
        return (v == '0) ? tmr_t'(1) : tmr_t'(v);
    endfunction

    function automatic void go(input seq_phase_e p, input cfg_val_t t);
        ph  = p;
        tmr = span(t);
    endfunction

    function automatic void close_cmd();
        ph  = SEQ_IDLE;
        tmr = '0;
        fin = 1'b1;
    endfunction

    // a one is a short low pulse, a zero a long one
    function automatic void start_write_bit();
        go(SEQ_WR_LOW, shreg[0] ? timings.short_pulse_time : timings.long_slot_time);
    endfunction

    function automatic void read_bit_done();
        if (bitn == 3'd7) begin
            rx_last = shreg;
            close_cmd();
        end else begin
            bitn++;
            go(SEQ_RD_LOW, timings.short_pulse_time);
        end
    endfunction

    // one tick of the sequencer; the accepting tick is the first tick of the command
    function automatic owb_res_t predict_tick(input logic cv, input logic [1:0] op,
                                              input logic [7:0] tx, input logic lvl);
        owb_res_t r;
        logic     drv;
        fin = 1'b0;
        if (ph == SEQ_IDLE && cv && op != OP_NONE) begin
            err_flag = 1'b0;
            bitn     = '0;
            if (op == OP_RESET) begin
                go(SEQ_RST_LOW, timings.reset_low_time);
            end else if (op == OP_WRITE) begin
                shreg = tx;
                start_write_bit();
            end else begin
                shreg = '0;
                go(SEQ_RD_LOW, timings.short_pulse_time);
            end
        end

        drv = (ph == SEQ_RST_LOW || ph == SEQ_WR_LOW || ph == SEQ_RD_LOW);

        if (ph == SEQ_RD_WAIT) begin
            // a zero bit ends on the first high tick, no timeout
            if (lvl) read_bit_done();
        end else if (ph != SEQ_IDLE) begin
            if (tmr > 1) begin
                tmr--;
            end else begin
                case (ph)
                    SEQ_RST_LOW: begin
                        go(SEQ_RST_WAIT, timings.presence_sample_time);
                    end
                    SEQ_RST_WAIT: begin
                        if (lvl) begin
                            err_flag = 1'b1;
                            close_cmd();
                        end else begin
                            polls = timings.presence_poll_limit;
                            go(SEQ_RST_POLL, timings.short_pulse_time);
                        end
                    end
                    SEQ_RST_POLL: begin
                        if (polls == '0) begin
                            err_flag = 1'b1;
                            close_cmd();
                        end else begin
                            polls--;
                            if (lvl) go(SEQ_RST_REC, timings.presence_end_time);
                            else go(SEQ_RST_POLL, timings.short_pulse_time);
                        end
                    end
                    SEQ_WR_LOW: begin
                        go(SEQ_WR_REL, shreg[0] ? timings.long_slot_time
                                                : timings.short_pulse_time);
                    end
                    SEQ_WR_REL: begin
                        if (bitn == 3'd7) begin
                            close_cmd();
                        end else begin
                            bitn++;
                            shreg = shreg >> 1;
                            start_write_bit();
                        end
                    end
                    SEQ_RD_LOW: begin
                        go(SEQ_RD_REL, timings.read_sample_time);
                    end
                    SEQ_RD_REL: begin
                        if (lvl) begin
                            shreg = {1'b1, shreg[7:1]};
                            go(SEQ_RD_TAIL, timings.read_tail_time);
                        end else begin
                            shreg = shreg >> 1;
                            ph    = SEQ_RD_WAIT;
                            tmr   = '0;
                        end
                    end
                    SEQ_RD_TAIL: begin
                        read_bit_done();
                    end
                    default: begin
                        // recovery end and anything unexpected
                        close_cmd();
                    end
                endcase
            end
        end

        r.drive_low = drv;
        r.busy_res  = (ph != SEQ_IDLE);
        r.done_res  = fin;
        r.rx_byte   = rx_last;
        r.status    = err_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // one tick transaction; the expectation comes from the table when typed
    task automatic send_tick(input logic cv, input logic [1:0] op, input logic [7:0] tx,
                             input logic lvl, input logic typed, input owb_res_t want);
        owb_res_t pred;
        if (!no_idling && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {op, cv};
        s_tdata  <= {7'b0, lvl, tx};
        do @(posedge aclk); while (!s_tready);
        pred = predict_tick(cv, op, tx, lvl);
        expected_ticks.push_back(typed ? want : pred);
        sent_ticks++;
    endtask

    // idle ticks until the running command has finished
    task automatic drain(input fill_e mode);
        logic l;
        while (ph != SEQ_IDLE) begin
            case (mode)
                FILL_LOW:  l = 1'b0;
                FILL_HIGH: l = 1'b1;
                FILL_TOGGLE: begin
                    toggle_lvl = ~toggle_lvl;
                    l = toggle_lvl;
                end
                default:   l = ($urandom_range(0, 99) < lvl_bias);
            endcase
            send_tick(1'b0, 2'($urandom), 8'($urandom), l, 1'b0, RES_IDLE);
        end
    endtask

    // stop sending and wait until every result is back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
    endtask

    // all eight registers back to back, only while nothing is in flight
    task automatic load_timings(input owb_cfg_t c);
        cfg_idx_t idx[8];
        cfg_val_t val[8];
        idx = '{REG_RESET_LOW, REG_PRES_SAMPLE, REG_PRES_END, REG_LONG_SLOT,
                REG_SHORT_PULSE, REG_READ_SAMPLE, REG_READ_TAIL, REG_POLL_LIMIT};
        val = '{c.reset_low_time, c.presence_sample_time, c.presence_end_time,
                c.long_slot_time, c.short_pulse_time, c.read_sample_time,
                c.read_tail_time, c.presence_poll_limit};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
        end
        cfg_we  <= 1'b0;
        timings = c;
    endtask

    // random ticks: mostly commands issued at idle, plus noise while busy
    task automatic run_random(input int n);
        logic       cv;
        logic [1:0] op;
        int         r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (ph == SEQ_IDLE && r < 55) begin
                cv = 1'b1;
                case ($urandom_range(0, 2))
                    0:       op = OP_RESET;
                    1:       op = OP_WRITE;
                    default: op = OP_READ;
                endcase
                // line mostly low, even or mostly high for this command
                case ($urandom_range(0, 2))
                    0:       lvl_bias = 15;
                    1:       lvl_bias = 50;
                    default: lvl_bias = 85;
                endcase
            end else if (ph == SEQ_IDLE && r < 62) begin
                cv = 1'b1;
                op = OP_NONE;
            end else begin
                cv = (ph != SEQ_IDLE && r < 5);
                op = 2'($urandom);
            end
            send_tick(cv, op, 8'($urandom), ($urandom_range(0, 99) < lvl_bias),
                      1'b0, RES_IDLE);
        end
        drain(FILL_RANDOM);
        wait_results();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        owb_cfg_t c;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // register values straight out of reset: one full write
        send_tick(1'b1, OP_WRITE, 8'h96, 1'b1, 1'b0, RES_IDLE);
        drain(FILL_RANDOM);
        wait_results();

        // directed table
        load_timings(FAST_TIMINGS);
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_tick(DIRECTED[i].cv, DIRECTED[i].op, DIRECTED[i].tx, DIRECTED[i].lvl,
                      DIRECTED[i].typed, DIRECTED[i].want);
            if (DIRECTED[i].fill != FILL_NONE) drain(DIRECTED[i].fill);
        end
        drain(FILL_TOGGLE);
        wait_results();

        // zero-length short pulse and reset phases, widest poll limit
        c = '{10'd0, 10'd0, 10'd7, 10'd9, 10'd0, 10'd6, 10'd8, CFG_MAX};
        load_timings(c);
        send_tick(1'b1, OP_RESET, 8'($urandom), 1'b0, 1'b0, RES_IDLE);
        drain(FILL_TOGGLE);
        send_tick(1'b1, OP_WRITE, 8'($urandom), 1'b0, 1'b0, RES_IDLE);
        drain(FILL_RANDOM);
        send_tick(1'b1, OP_READ, 8'($urandom), 1'b1, 1'b0, RES_IDLE);
        drain(FILL_TOGGLE);
        wait_results();

        // short random timings, zeros included; the tail runs without gaps
        while (sent_ticks < ITEMS) begin
            if (sent_ticks >= ITEMS - 350) no_idling = 1'b1;
            c.reset_low_time       = cfg_val_t'($urandom_range(0, 6));
            c.presence_sample_time = cfg_val_t'($urandom_range(0, 6));
            c.presence_end_time    = cfg_val_t'($urandom_range(0, 6));
            c.long_slot_time       = cfg_val_t'($urandom_range(0, 6));
            c.short_pulse_time     = cfg_val_t'($urandom_range(0, 4));
            c.read_sample_time     = cfg_val_t'($urandom_range(0, 6));
            c.read_tail_time       = cfg_val_t'($urandom_range(0, 6));
            c.presence_poll_limit  = cfg_val_t'($urandom_range(0, 4));
            load_timings(c);
            run_random($urandom_range(80, 200));
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("onewire_bus_master: match");
        end else begin
            $display("onewire_bus_master: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    // back-pressure in short random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!no_idling && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < 20)
            $display("tick result %0d: %s is %0h, expected %0h", result_idx, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        owb_res_t got;
        owb_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = owb_res_t'(m_tdata[11:0]);
            if (expected_ticks.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_tdata), 0);
            end else begin
                want = expected_ticks.pop_front();
                if (got.drive_low !== want.drive_low)
                    report_mismatch("drive_low", 32'(got.drive_low), 32'(want.drive_low));
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
                if (got.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", 32'(got.rx_byte), 32'(want.rx_byte));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
            end
            result_idx++;
        end
    end

    // ends the run when neither stream moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("onewire_bus_master: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/owb_pkg.sv
hw/rtl/owb_seq.sv
hw/rtl/onewire_bus_master.sv
test/tb.sv
